// File: rtl/cklp_pkg.sv
// Shared types and constants of the configuration line parser.
package cklp_pkg;

  // Character constants
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;

  // char_kind codes
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindName  = 2'd1;
  localparam logic [1:0] KindValue = 2'd2;

  // status codes
  localparam logic [2:0] StRun      = 3'd0;
  localparam logic [2:0] StEnd      = 3'd1;
  localparam logic [2:0] StEndName  = 3'd2;
  localparam logic [2:0] StNoEquals = 3'd3;
  localparam logic [2:0] StEndValue = 3'd4;

  // Byte class flags, worked out in the front end
  typedef struct packed {
    logic is_zero;
    logic is_blank;
    logic is_eol;
    logic is_eq;
    logic is_name;
    logic is_low;
  } cklp_class_t;

  // One queued word
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        restart;
    cklp_class_t cls;
  } cklp_entry_t;

endpackage

// File: rtl/cklp_front.sv
// Front end: accepts input words and classifies each byte.
module cklp_front
  import cklp_pkg::*;
(
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        restart_i,
  input  logic        full_i,
  output logic        push_o,
  output cklp_entry_t entry_o
);

  cklp_class_t cls;

  always_comb begin
    cls.is_zero  = (text_byte_i == CharNul);
    cls.is_blank = (text_byte_i != CharNul) && (text_byte_i <= CharSpace);
    cls.is_eol   = (text_byte_i == CharCr) || (text_byte_i == CharLf);
    cls.is_eq    = (text_byte_i == CharEq);
    cls.is_low   = (text_byte_i < CharA);
    cls.is_name  = (text_byte_i >= CharA) ||
                   ((text_byte_i >= Char0) && (text_byte_i <= Char9));
  end

  assign in_ready_o        = !full_i;
  assign push_o            = in_valid_i && !full_i;
  assign entry_o.text_byte = text_byte_i;
  assign entry_o.restart   = restart_i;
  assign entry_o.cls       = cls;

endmodule

// File: rtl/cklp_queue.sv
// Small FIFO of classified words between front and back end.
module cklp_queue
  import cklp_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cklp_entry_t push_data_i,
  input  logic        pop_i,
  output cklp_entry_t pop_data_o,
  output logic        not_empty_o,
  output logic        full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cklp_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/cklp_back.sv
// Back end: parse state machine and registered result word.
module cklp_back
  import cklp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cklp_entry_t q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  char_out_o,
  output logic [1:0]  char_kind_o,
  output logic        entry_done_o,
  output logic [2:0]  status_o
);

  localparam logic [2:0] PhLine    = 3'd0;
  localparam logic [2:0] PhComment = 3'd1;
  localparam logic [2:0] PhName    = 3'd2;
  localparam logic [2:0] PhPost    = 3'd3;
  localparam logic [2:0] PhPre     = 3'd4;
  localparam logic [2:0] PhValue   = 3'd5;
  localparam logic [2:0] PhHalt    = 3'd6;

  logic [2:0]  phase_q, phase_d, phase_cur;
  logic [2:0]  halt_q, halt_d, halt_cur;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  char_q;
  logic [1:0]  kind_q, kind_d;
  logic        done_q, done_d;
  logic [2:0]  status_q, status_d;
  logic        load;
  cklp_class_t c;

  assign c    = q_data_i.cls;
  assign load = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = load;

  always_comb begin
    phase_cur = q_data_i.restart ? PhLine : phase_q;
    halt_cur  = q_data_i.restart ? StRun : halt_q;
    phase_d   = phase_cur;
    halt_d    = halt_cur;
    kind_d    = KindNone;
    done_d    = 1'b0;
    status_d  = StRun;
    unique case (phase_cur)
      PhLine: begin
        if (c.is_zero) status_d = StEnd;
        else if (c.is_blank) phase_d = PhLine;
        else if (c.is_low) phase_d = PhComment;
        else begin
          kind_d  = KindName;
          phase_d = PhName;
        end
      end
      PhComment: begin
        if (c.is_zero) status_d = StEnd;
        else if (c.is_eol) phase_d = PhLine;
      end
      PhName: begin
        if (c.is_name) kind_d = KindName;
        else if (c.is_zero) status_d = StEndName;
        else if (c.is_blank) phase_d = PhPost;
        else if (c.is_eq) phase_d = PhPre;
        else status_d = StNoEquals;
      end
      PhPost: begin
        if (c.is_blank) phase_d = PhPost;
        else if (c.is_eq) phase_d = PhPre;
        else status_d = StNoEquals;
      end
      PhPre: begin
        if (c.is_zero) status_d = StEndValue;
        else if (c.is_eol) begin
          done_d  = 1'b1;
          phase_d = PhLine;
        end else if (c.is_blank) phase_d = PhPre;
        else begin
          kind_d  = KindValue;
          phase_d = PhValue;
        end
      end
      PhValue: begin
        if (c.is_zero) begin
          done_d   = 1'b1;
          status_d = StEnd;
        end else if (c.is_eol) begin
          done_d  = 1'b1;
          phase_d = PhLine;
        end else kind_d = KindValue;
      end
      default: status_d = halt_cur;  // halted, also the unused code
    endcase
    if (status_d != StRun) begin
      phase_d = PhHalt;
      halt_d  = status_d;
    end
  end

  always_comb begin
    if (load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLine;
      halt_q      <= StRun;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        phase_q <= phase_d;
        halt_q  <= halt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q   <= q_data_i.text_byte;
      kind_q   <= kind_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_out_o   = char_q;
  assign char_kind_o  = kind_q;
  assign entry_done_o = done_q;
  assign status_o     = status_q;

endmodule

// File: rtl/config_line_key_value_parser.sv
// Top level of the streaming name=value configuration line parser.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------------
//  in      | in  | in_valid_i/in_ready_o  | text_byte_i[7:0], restart_i
//  out     | out | out_valid_o/out_ready_i| char_out_o[7:0], char_kind_o[1:0],
//          |     |                        | entry_done_o, status_o[2:0]
//
// One word in, one word out; a new byte can be taken every cycle while the queue is not full.
// A word passes through the classify queue and then the output register
// of the parse state machine.
// Reset (rst_ni low) empties the queue, drops out_valid_o and puts the
// parser at line start with no halt status.
// The queue lets the front keep taking bytes for QueueDepth words while
// the output is stalled; in_ready_o falls only once the queue is full.
module config_line_key_value_parser
  import cklp_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] char_out_o,
  output logic [1:0] char_kind_o,
  output logic       entry_done_o,
  output logic [2:0] status_o
);

  // front -> queue
  logic        push;
  cklp_entry_t push_data;
  logic        q_full;

  // queue -> back
  cklp_entry_t pop_data;
  logic        q_not_empty;
  logic        pop;

  // Classifies every accepted byte (blank, eol, '=', name char, zero, below 'A')
  cklp_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .restart_i   (restart_i),
    .full_i      (q_full),
    .push_o      (push),
    .entry_o     (push_data)
  );

  // Decouples input acceptance from output back-pressure
  cklp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  // Parse phase machine; steps once per word moved into the output register
  cklp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_not_empty),
    .q_data_i     (pop_data),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_out_o   (char_out_o),
    .char_kind_o  (char_kind_o),
    .entry_done_o (entry_done_o),
    .status_o     (status_o)
  );

  // An end or error word never carries a token byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StRun) |-> char_kind_o == KindNone)
    else $error("token kind on a halting word");

  // Entry completion happens on a terminator, never on a token byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_done_o) |-> char_kind_o == KindNone)
    else $error("entry done on a token byte");

  // Name bytes are digits or at/above 'A'; checked here only as not below '0'
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && char_kind_o == KindName) |-> char_out_o >= Char0)
    else $error("name byte out of range");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the streaming name=value configuration line parser.
`timescale 1ns / 100ps

module testbench;
  import cklp_pkg::*;

  localparam int IdleLimit = 500;   // cycles with no handshake before giving up
  localparam int LongHold  = 60;    // receiver hold-off, long enough to fill the queue
  localparam int TextBytes = 550;   // input words per run, directed ones included

  // Parser phases as tracked by the predictor
  typedef enum logic [2:0] {
    PhLine, PhComment, PhName, PhPost, PhPre, PhValue, PhHalt
  } parse_phase_e;

  // One tagged output word
  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic       done;
    logic [2:0] st;
  } tag_word_t;

  // Tracks the parse of the accepted text and holds the tags still owed by the block.
  class parse_tracker;
    parse_phase_e phase;
    logic [2:0]   halt_status;
    tag_word_t    expected_tags[$];
    int errors, bytes_seen, entries, text_ends, syntax_halts;

    function new();
      phase       = PhLine;
      halt_status = StRun;
    endfunction

    // Works out the tag word of one accepted text byte.
    function void take_byte(logic [7:0] c, logic rs);
      tag_word_t w;
      logic blank, eol, name_ch;
      blank   = (c != CharNul) && (c <= CharSpace);
      eol     = (c == CharCr) || (c == CharLf);
      name_ch = (c >= CharA) || ((c >= Char0) && (c <= Char9));
      w = '{ch: c, kind: KindNone, done: 1'b0, st: StRun};
      bytes_seen++;
      if (rs) begin
        phase       = PhLine;
        halt_status = StRun;
      end
      case (phase)
        PhLine: begin
          if (c == CharNul) w.st = StEnd;
          else if (blank) ;
          else if (c < CharA) phase = PhComment;
          else begin
            w.kind = KindName;
            phase  = PhName;
          end
        end
        PhComment: begin
          if (c == CharNul) w.st = StEnd;
          else if (eol) phase = PhLine;
        end
        PhName: begin
          if (name_ch) w.kind = KindName;
          else if (c == CharNul) w.st = StEndName;
          else if (blank) phase = PhPost;
          else if (c == CharEq) phase = PhPre;
          else w.st = StNoEquals;
        end
        PhPost: begin
          if (blank) ;
          else if (c == CharEq) phase = PhPre;
          else w.st = StNoEquals;
        end
        PhPre: begin
          if (c == CharNul) w.st = StEndValue;
          else if (eol) begin
            w.done = 1'b1;
            phase  = PhLine;
          end else if (blank) ;
          else begin
            w.kind = KindValue;
            phase  = PhValue;
          end
        end
        PhValue: begin
          if (c == CharNul) begin
            w.done = 1'b1;
            w.st   = StEnd;
          end else if (eol) begin
            w.done = 1'b1;
            phase  = PhLine;
          end else w.kind = KindValue;
        end
        default: w.st = halt_status;
      endcase
      if (w.done) entries++;
      if (w.st != StRun) begin
        if (phase != PhHalt) begin
          if (w.st == StEnd) text_ends++;
          else syntax_halts++;
        end
        phase       = PhHalt;
        halt_status = w.st;
      end
      expected_tags.push_back(w);
    endfunction

    // Compares one accepted output word with the oldest expected tag.
    function void check_word(logic [7:0] ch, logic [1:0] kind, logic done, logic [2:0] st);
      tag_word_t w;
      if (expected_tags.size() == 0) begin
        $error("unexpected word: char_out %02h char_kind %0d entry_done %0d status %0d",
               ch, kind, done, st);
        errors++;
        return;
      end
      w = expected_tags.pop_front();
      if (ch !== w.ch) begin
        $error("char_out: expected %02h, got %02h", w.ch, ch);
        errors++;
      end
      if (kind !== w.kind) begin
        $error("char_kind: expected %0d, got %0d (byte %02h)", w.kind, kind, w.ch);
        errors++;
      end
      if (done !== w.done) begin
        $error("entry_done: expected %0d, got %0d (byte %02h)", w.done, done, w.ch);
        errors++;
      end
      if (st !== w.st) begin
        $error("status: expected %0d, got %0d (byte %02h)", w.st, st, w.ch);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] text_byte_i;
  logic       restart_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] char_out_o;
  logic [1:0] char_kind_o;
  logic       entry_done_o;
  logic [2:0] status_o;

  parse_tracker tracker = new();

  bit no_gaps;        // both sides skip idling while set
  bit hold_req;       // main asks the receiver for one long hold-off
  bit restart_next;   // next byte put by the generator carries restart
  int sent;
  int idle_cycles;

  config_line_key_value_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_out_o   (char_out_o),
    .char_kind_o  (char_kind_o),
    .entry_done_o (entry_done_o),
    .status_o     (status_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Both monitors sample at the edge, ahead of the nonblocking updates.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.take_byte(text_byte_i, restart_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_word(char_out_o, char_kind_o, entry_done_o, status_o);
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no word moved for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random hold-off per word, one long stall on request.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = LongHold;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one word and returns at the edge where it is taken.
  // Valid stays high across back-to-back words; it only drops for a gap.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    restart_i   <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Generator byte: takes a pending restart, or a rare stray one.
  task automatic put(input logic [7:0] b, input logic stray_restart = 1'b0);
    send_byte(b, restart_next | stray_restart);
    restart_next = 1'b0;
  endtask

  function automatic logic [7:0] rand_blank();
    return 8'($urandom_range(1, 32));
  endfunction

  // Blank that does not end the line
  function automatic logic [7:0] rand_pad();
    logic [7:0] v;
    do v = rand_blank(); while (v == CharCr || v == CharLf);
    return v;
  endfunction

  function automatic logic [7:0] rand_name_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(Char0, Char9));
    return 8'($urandom_range(CharA, 255));
  endfunction

  // Any byte that neither ends the text nor the line
  function automatic logic [7:0] rand_text_char();
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == CharCr || v == CharLf);
    return v;
  endfunction

  function automatic logic [7:0] rand_eol();
    return $urandom_range(0, 1) ? CharCr : CharLf;
  endfunction

  // One text: a few lines, mostly well-formed entries, ended by a NUL.
  // Restart is set on the first byte so each text starts from a clean parser.
  task automatic emit_text();
    int lines, pick;
    bit last_entry;
    lines        = $urandom_range(1, 6);
    no_gaps      = ($urandom_range(0, 3) == 0);
    restart_next = 1'b1;
    last_entry   = 1'b0;
    for (int ln = 0; ln < lines; ln++) begin
      pick       = $urandom_range(0, 19);
      last_entry = 1'b0;
      if (pick < 12) begin
        // name [blanks] = [pad] value eol
        repeat ($urandom_range(0, 2)) put(rand_blank());
        put(8'($urandom_range(CharA, 255)));
        repeat ($urandom_range(0, 4)) put(rand_name_char());
        repeat ($urandom_range(0, 2)) put(rand_blank());
        put(CharEq);
        repeat ($urandom_range(0, 2)) put(rand_pad());
        repeat ($urandom_range(0, 6)) put(rand_text_char());
        if (ln == lines - 1 && $urandom_range(0, 2) == 0) last_entry = 1'b1;
        else put(rand_eol());
      end else if (pick < 15) begin
        // comment: first byte below 'A' and not blank
        put(8'($urandom_range(CharSpace + 1, CharA - 1)));
        repeat ($urandom_range(0, 6)) put(rand_text_char());
        put(rand_eol());
      end else if (pick < 17) begin
        // name followed by any byte at all, often a syntax error
        put(8'($urandom_range(CharA, 255)));
        repeat ($urandom_range(0, 2)) put(rand_name_char());
        put(8'($urandom_range(0, 255)));
        put(rand_eol());
      end else begin
        // raw noise, with the odd restart in the middle of a line
        repeat ($urandom_range(1, 4))
          put(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
    // A value left open at the end is closed by the NUL itself; an empty one halts with StEndValue.
    put(CharNul);
    if (last_entry || $urandom_range(0, 3) == 0) begin
      // a few bytes while halted, before the next text restarts the parser
      repeat ($urandom_range(0, 2)) put(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    text_byte_i  = 8'h00;
    restart_i    = 1'b0;
    no_gaps      = 1'b0;
    hold_req     = 1'b0;
    restart_next = 1'b0;
    sent         = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: blanks at both ends of their range, name bytes at 'A', 0xFF and digits,
    // a tab after the name, pad before the value, value ended by CR.
    send_byte(8'h01, 1'b0);
    send_byte(CharSpace, 1'b0);
    send_byte(CharA, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(Char0, 1'b0);
    send_byte(Char9, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(CharEq, 1'b0);
    send_byte(CharSpace, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CharCr, 1'b0);
    // empty value closed by LF
    send_byte("K", 1'b0);
    send_byte(CharEq, 1'b0);
    send_byte(CharLf, 1'b0);
    // digit at line start opens a comment; NUL inside it ends the text
    send_byte(Char0, 1'b0);
    send_byte(CharNul, 1'b0);
    // halted: status repeats without restart
    send_byte("Q", 1'b0);
    // NUL inside a name
    send_byte("N", 1'b1);
    send_byte(CharNul, 1'b0);
    // stray byte after a name
    send_byte("N", 1'b1);
    send_byte("!", 1'b0);
    // NUL after the name's trailing blank
    send_byte("N", 1'b1);
    send_byte(CharSpace, 1'b0);
    send_byte(CharNul, 1'b0);
    // NUL right after the equals sign
    send_byte("N", 1'b1);
    send_byte(CharEq, 1'b0);
    send_byte(CharNul, 1'b0);
    // NUL closes an open value and ends the text together
    send_byte("N", 1'b1);
    send_byte(CharEq, 1'b0);
    send_byte("v", 1'b0);
    send_byte(CharNul, 1'b0);

    // Random texts; the receiver stalls long once so the queue fills up.
    hold_req = 1'b1;
    while (sent < TextBytes) emit_text();
    in_valid_i <= 1'b0;

    while (tracker.expected_tags.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Parsed %0d bytes: %0d entries completed, %0d ends of text, %0d syntax halts.",
             tracker.bytes_seen, tracker.entries, tracker.text_ends, tracker.syntax_halts);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cklp_pkg.sv
rtl/cklp_front.sv
rtl/cklp_queue.sv
rtl/cklp_back.sv
rtl/config_line_key_value_parser.sv
tb/testbench.sv
